// ===== sv/lmts_pkg.sv =====
// Package: shared constants, types and the 8x8 font for the LED matrix text scroller.
`default_nettype none

package lmts_pkg;

  localparam int unsigned GLYPH_ROWS           = 8;
  localparam int unsigned ROW_W                = 8;
  localparam int unsigned ROW_IDX_W            = $clog2(GLYPH_ROWS);
  localparam int unsigned STEP_W               = 2 * ROW_IDX_W;
  localparam int unsigned FONT_SLOTS           = 64;
  localparam int unsigned FONT_ENTRIES_DEFAULT = 47;
  localparam logic [7:0]  FONT_FIRST           = 8'd46;
  localparam logic [STEP_W-1:0]    LAST_STEP   = '1;
  localparam logic [ROW_IDX_W-1:0] LAST_ROW    = '1;

  typedef logic [GLYPH_ROWS*ROW_W-1:0] glyph_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCROLL
  } lmts_state_e;

  // Controller to datapath
  typedef struct packed {
    logic              capture;
    logic              load;
    logic              emit;
    logic [STEP_W-1:0] step;
  } lmts_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic slot_free;
  } lmts_sts_t;

  // Glyph for a font slot, row 0 in the top byte; slots past the built-in set are blank
  function automatic glyph_t font_glyph(input logic [5:0] slot);
    glyph_t g;
    unique case (slot)
      6'd0:    g = 64'h00000000_00181800;
      6'd1:    g = 64'h01626408_10264680;
      6'd2:    g = 64'h3C424242_4242423C;
      6'd3:    g = 64'h10305010_1010107C;
      6'd4:    g = 64'h7E02027E_4040407E;
      6'd5:    g = 64'h3E02023E_02023E00;
      6'd6:    g = 64'h08182848_FE080808;
      6'd7:    g = 64'h3C20203C_04043C00;
      6'd8:    g = 64'h3C20203C_24243C00;
      6'd9:    g = 64'h3E220408_08080808;
      6'd10:   g = 64'h003E2222_3E22223E;
      6'd11:   g = 64'h3E22223E_0202023E;
      6'd12:   g = 64'h00181800_00181800;
      6'd13:   g = 64'h00181810_00000000;
      6'd14:   g = 64'h08102040_20100800;
      6'd15:   g = 64'h003C3C00_003C3C00;
      6'd16:   g = 64'h20100804_08102000;
      6'd17:   g = 64'h3C242408_10100010;
      6'd18:   g = 64'h00000000_00000000;
      6'd19:   g = 64'h18244242_7E424242;
      6'd20:   g = 64'h3C22223C_22223C00;
      6'd21:   g = 64'h3C404040_4040403C;
      6'd22:   g = 64'h7C222222_2222227C;
      6'd23:   g = 64'h7C40407C_4040407C;
      6'd24:   g = 64'h7C40407C_40404040;
      6'd25:   g = 64'h3C404040_4C44443C;
      6'd26:   g = 64'h4444447C_44444444;
      6'd27:   g = 64'h7C101010_1010107C;
      6'd28:   g = 64'h3C080808_08084830;
      6'd29:   g = 64'h00242830_20302824;
      6'd30:   g = 64'h40404040_4040407C;
      6'd31:   g = 64'h81C3A599_81818181;
      6'd32:   g = 64'h00426252_4A464200;
      6'd33:   g = 64'h3C424242_4242423C;
      6'd34:   g = 64'h3C222222_3C202020;
      6'd35:   g = 64'h1C222222_2226221D;
      6'd36:   g = 64'h3C222222_3C242221;
      6'd37:   g = 64'h001E2020_3E02023C;
      6'd38:   g = 64'h003E0808_08080808;
      6'd39:   g = 64'h42424242_4242221C;
      6'd40:   g = 64'h42424242_42422418;
      6'd41:   g = 64'h00494949_492A1C00;
      6'd42:   g = 64'h00412214_08142241;
      6'd43:   g = 64'h41221408_08080808;
      6'd44:   g = 64'h007F0204_0810207F;
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

// ===== sv/lmts_if.sv =====
// Interfaces: character input channel and row write output channel.
`default_nettype none

interface lmts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       starts_message;

  modport source (output valid, output char_code, output starts_message, input ready);
  modport sink   (input valid, input char_code, input starts_message, output ready);
endinterface

interface lmts_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] digit_register;
  logic [7:0] row_bits;
  logic [2:0] shift_step;
  logic       last_of_run;

  modport source (output valid, output digit_register, output row_bits,
                  output shift_step, output last_of_run, input ready);
  modport sink   (input valid, input digit_register, input row_bits,
                  input shift_step, input last_of_run, output ready);
endinterface

`default_nettype wire

// ===== sv/lmts_ctrl.sv =====
// Controller: sequences glyph loads and the 64 row writes of a scroll.
`default_nettype none

module lmts_ctrl
  import lmts_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic      in_starts_i,
  output logic           in_ready_o,
  input  wire lmts_sts_t sts_i,
  output lmts_cmd_t      cmd_o
);

  lmts_state_e       state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    cmd_o.step   = step_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          step_d        = '0;
          state_d       = in_starts_i ? ST_LOAD : ST_SCROLL;
        end
      end
      ST_LOAD: begin
        // One stored row per cycle
        cmd_o.load = 1'b1;
        step_d     = step_q + 1'b1;
        if (step_q[ROW_IDX_W-1:0] == LAST_ROW) begin
          step_d  = '0;
          state_d = ST_IDLE;
        end
      end
      ST_SCROLL: begin
        // Advance only when the output register can take a beat
        if (sts_i.slot_free) begin
          cmd_o.emit = 1'b1;
          step_d     = step_q + 1'b1;
          if (step_q == LAST_STEP) begin
            step_d  = '0;
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
        step_d  = '0;
      end
    endcase
  end

  a_start_to_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && in_valid_i && in_starts_i) |=> (state_q == ST_LOAD))
    else $error("message start did not enter glyph load");

  a_scroll_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCROLL && sts_i.slot_free && step_q == LAST_STEP)
      |=> (state_q == ST_IDLE && step_q == '0))
    else $error("scroll did not finish after final row write");

  a_step_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCROLL && !sts_i.slot_free) |=> (state_q == ST_SCROLL && $stable(step_q)))
    else $error("scroll advanced while output stalled");

endmodule

`default_nettype wire

// ===== sv/lmts_dp.sv =====
// Datapath: character register, stored rows, font lookup and output register.
`default_nettype none

module lmts_dp
  import lmts_pkg::*;
#(
  parameter int unsigned FONT_ENTRIES = FONT_ENTRIES_DEFAULT
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire lmts_cmd_t  cmd_i,
  output lmts_sts_t       sts_o,
  input  wire logic [7:0] in_char_code_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [3:0]      out_digit_register_o,
  output logic [7:0]      out_row_bits_o,
  output logic [2:0]      out_shift_step_o,
  output logic            out_last_of_run_o
);

  logic [7:0]       char_q;
  logic [ROW_W-1:0] shown_q [GLYPH_ROWS];
  logic             out_valid_q;
  logic [3:0]       digit_q;
  logic [7:0]       row_bits_q;
  logic [2:0]       shift_q;
  logic             last_q;

  logic [ROW_IDX_W-1:0] row_idx;
  logic [ROW_IDX_W-1:0] frame_idx;
  logic [7:0]           slot_off;
  logic                 in_font;
  glyph_t               glyph;
  logic [ROW_W-1:0]     glyph_row;
  logic [ROW_W-1:0]     shifted_row;

  assign row_idx   = cmd_i.step[ROW_IDX_W-1:0];
  assign frame_idx = cmd_i.step[STEP_W-1:ROW_IDX_W];

  assign slot_off  = char_q - FONT_FIRST;
  assign in_font   = (char_q >= FONT_FIRST) && (slot_off < 8'(FONT_ENTRIES));
  assign glyph     = in_font ? font_glyph(slot_off[5:0]) : '0;
  assign glyph_row = glyph[(GLYPH_ROWS - 1 - row_idx) * ROW_W +: ROW_W];

  // Shift left, take glyph bit 7 in the first frame down to bit 0 in the last
  assign shifted_row = {shown_q[row_idx][ROW_W-2:0], glyph_row[~frame_idx]};

  assign sts_o.slot_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      char_q <= in_char_code_i;
    end
    if (cmd_i.emit) begin
      digit_q    <= {1'b0, row_idx} + 4'd1;
      row_bits_q <= shifted_row;
      shift_q    <= frame_idx;
      last_q     <= (cmd_i.step == LAST_STEP);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < GLYPH_ROWS; i++) begin
        shown_q[i] <= '0;
      end
    end else if (cmd_i.load) begin
      shown_q[row_idx] <= glyph_row;
    end else if (cmd_i.emit) begin
      shown_q[row_idx] <= shifted_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign out_digit_register_o = digit_q;
  assign out_row_bits_o       = row_bits_q;
  assign out_shift_step_o     = shift_q;
  assign out_last_of_run_o    = last_q;

  a_emit_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> sts_o.slot_free)
    else $error("row write issued over an unread beat");

  a_emit_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && cmd_i.step == LAST_STEP) |=> (out_valid_q && last_q && digit_q == 4'd8))
    else $error("final row write not flagged");

endmodule

`default_nettype wire

// ===== sv/led_matrix_text_scroller.sv =====
// Usage notes:
// Input channel in_i carries one character per beat: char_code and
// starts_message. Output channel out_o carries one matrix row write per
// beat: digit_register (1..8), row_bits, shift_step and last_of_run.
// A character with starts_message set loads its glyph into the stored
// rows, one stored row per cycle, and gives no beats. Any other
// character gives 64 beats, eight frames of rows 1 to 8, one beat per
// cycle while the receiver keeps ready high. The first beat appears once
// the controller is in its scroll state and the row is registered in the
// output register. The next character is accepted once the last beat
// sits in the output register.
// When the receiver drops ready the output register holds its beat and
// the scroll pauses in place, losing nothing.
// Reset clears the stored rows to blank and empties the output register.
// Codes outside the font scroll in as a blank glyph.
`default_nettype none

module led_matrix_text_scroller
  import lmts_pkg::*;
#(
  parameter int unsigned FONT_ENTRIES = FONT_ENTRIES_DEFAULT
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  lmts_in_if.sink    in_i,
  lmts_out_if.source out_o
);

  lmts_cmd_t cmd;
  lmts_sts_t sts;

  lmts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_starts_i (in_i.starts_message),
    .in_ready_o  (in_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lmts_dp #(
    .FONT_ENTRIES (FONT_ENTRIES)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .in_char_code_i       (in_i.char_code),
    .out_valid_o          (out_o.valid),
    .out_ready_i          (out_o.ready),
    .out_digit_register_o (out_o.digit_register),
    .out_row_bits_o       (out_o.row_bits),
    .out_shift_step_o     (out_o.shift_step),
    .out_last_of_run_o    (out_o.last_of_run)
  );

endmodule

`default_nettype wire

// ===== verif/lmts_scroll_checker.sv =====
// Checker for the LED matrix text scroller: predicts every row write and compares each beat.
`timescale 1ns / 1ps

module lmts_scroll_checker
  import lmts_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       char_valid_i,
  input  wire logic       char_ready_i,
  input  wire logic [7:0] char_code_i,
  input  wire logic       starts_message_i,
  input  wire logic       row_valid_i,
  input  wire logic       row_ready_i,
  input  wire logic [3:0] digit_register_i,
  input  wire logic [7:0] row_bits_i,
  input  wire logic [2:0] shift_step_i,
  input  wire logic       last_of_run_i,
  output int unsigned     mismatches_o,
  output int unsigned     pending_o,
  output int unsigned     rows_checked_o
);

  localparam int unsigned REPORT_CAP = 50;

  typedef struct packed {
    logic [3:0] digit;
    logic [7:0] bits;
    logic [2:0] step;
    logic       last;
  } row_write_t;

  logic [7:0] panel_rows [GLYPH_ROWS];
  row_write_t expected_rows [$];

  // Bitmap of a character, top row in the upper byte; anything else is blank
  function automatic logic [63:0] glyph_bitmap(input logic [7:0] code);
    case (code)
      8'd46:   return 64'h00000000_00181800;
      8'd47:   return 64'h01626408_10264680;
      8'd48:   return 64'h3C424242_4242423C;
      8'd49:   return 64'h10305010_1010107C;
      8'd50:   return 64'h7E02027E_4040407E;
      8'd51:   return 64'h3E02023E_02023E00;
      8'd52:   return 64'h08182848_FE080808;
      8'd53:   return 64'h3C20203C_04043C00;
      8'd54:   return 64'h3C20203C_24243C00;
      8'd55:   return 64'h3E220408_08080808;
      8'd56:   return 64'h003E2222_3E22223E;
      8'd57:   return 64'h3E22223E_0202023E;
      8'd58:   return 64'h00181800_00181800;
      8'd59:   return 64'h00181810_00000000;
      8'd60:   return 64'h08102040_20100800;
      8'd61:   return 64'h003C3C00_003C3C00;
      8'd62:   return 64'h20100804_08102000;
      8'd63:   return 64'h3C242408_10100010;
      8'd65:   return 64'h18244242_7E424242;
      8'd66:   return 64'h3C22223C_22223C00;
      8'd67:   return 64'h3C404040_4040403C;
      8'd68:   return 64'h7C222222_2222227C;
      8'd69:   return 64'h7C40407C_4040407C;
      8'd70:   return 64'h7C40407C_40404040;
      8'd71:   return 64'h3C404040_4C44443C;
      8'd72:   return 64'h4444447C_44444444;
      8'd73:   return 64'h7C101010_1010107C;
      8'd74:   return 64'h3C080808_08084830;
      8'd75:   return 64'h00242830_20302824;
      8'd76:   return 64'h40404040_4040407C;
      8'd77:   return 64'h81C3A599_81818181;
      8'd78:   return 64'h00426252_4A464200;
      8'd79:   return 64'h3C424242_4242423C;
      8'd80:   return 64'h3C222222_3C202020;
      8'd81:   return 64'h1C222222_2226221D;
      8'd82:   return 64'h3C222222_3C242221;
      8'd83:   return 64'h001E2020_3E02023C;
      8'd84:   return 64'h003E0808_08080808;
      8'd85:   return 64'h42424242_4242221C;
      8'd86:   return 64'h42424242_42422418;
      8'd87:   return 64'h00494949_492A1C00;
      8'd88:   return 64'h00412214_08142241;
      8'd89:   return 64'h41221408_08080808;
      8'd90:   return 64'h007F0204_0810207F;
      default: return 64'h0;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches_o < REPORT_CAP) $display("%0t ns: %s", $realtime, msg);
    mismatches_o++;
  endtask

  // Load the glyph on a message start, otherwise queue the 64 row writes of its scroll
  task automatic predict_char(input logic [7:0] code, input logic start);
    logic [63:0] bitmap;
    logic [7:0]  glyph_row;
    row_write_t  beat;
    bitmap = glyph_bitmap(code);
    if (start) begin
      for (int r = 0; r < GLYPH_ROWS; r++) panel_rows[r] = bitmap[63-8*r -: 8];
    end else begin
      for (int f = 0; f < 8; f++) begin
        for (int r = 0; r < GLYPH_ROWS; r++) begin
          glyph_row     = bitmap[63-8*r -: 8];
          panel_rows[r] = {panel_rows[r][6:0], glyph_row[7-f]};
          beat.digit    = 4'(r + 1);
          beat.bits     = panel_rows[r];
          beat.step     = 3'(f);
          beat.last     = (f == 7) && (r == GLYPH_ROWS - 1);
          expected_rows.push_back(beat);
        end
      end
    end
  endtask

  task automatic check_row_write();
    row_write_t want;
    if (expected_rows.size() == 0) begin
      report_mismatch($sformatf("row write to digit %0d with nothing pending", digit_register_i));
    end else begin
      want = expected_rows.pop_front();
      rows_checked_o++;
      if (digit_register_i !== want.digit)
        report_mismatch($sformatf("digit_register %0d, expected %0d", digit_register_i,
                                  want.digit));
      if (row_bits_i !== want.bits)
        report_mismatch($sformatf("row_bits %02h, expected %02h (digit %0d, step %0d)",
                                  row_bits_i, want.bits, want.digit, want.step));
      if (shift_step_i !== want.step)
        report_mismatch($sformatf("shift_step %0d, expected %0d", shift_step_i, want.step));
      if (last_of_run_i !== want.last)
        report_mismatch($sformatf("last_of_run %0b, expected %0b (digit %0d, step %0d)",
                                  last_of_run_i, want.last, want.digit, want.step));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (panel_rows[r]) panel_rows[r] = '0;
      expected_rows.delete();
      mismatches_o   = 0;
      rows_checked_o = 0;
      pending_o     <= 0;
    end else begin
      if (row_valid_i && row_ready_i) check_row_write();
      if (char_valid_i && char_ready_i) predict_char(char_code_i, starts_message_i);
      pending_o <= expected_rows.size();
    end
  end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top: drives characters, stalls the row output and gives the verdict.
`timescale 1ns / 1ps

module tb_top
  import lmts_pkg::*;
();

  localparam int unsigned HALF_PERIOD  = 6;
  localparam int unsigned RESET_CYCLES = 10;
  localparam int unsigned RANDOM_CHARS = 360;
  localparam int unsigned CALM_TAIL    = 40;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam logic [7:0]  LAST_CODE    = 8'(FONT_FIRST + FONT_ENTRIES_DEFAULT - 1);

  logic clk_i;
  logic rst_ni;

  lmts_in_if  char_ch ();
  lmts_out_if row_ch ();

  int unsigned mismatches;
  int unsigned pending;
  int unsigned rows_checked;
  int unsigned cycles;
  int unsigned scrolls_sent;
  int unsigned loads_sent;
  bit          calm;

  initial clk_i = 1'b0;
  always #HALF_PERIOD clk_i = ~clk_i;

  led_matrix_text_scroller u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (char_ch),
    .out_o  (row_ch)
  );

  lmts_scroll_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .char_valid_i     (char_ch.valid),
    .char_ready_i     (char_ch.ready),
    .char_code_i      (char_ch.char_code),
    .starts_message_i (char_ch.starts_message),
    .row_valid_i      (row_ch.valid),
    .row_ready_i      (row_ch.ready),
    .digit_register_i (row_ch.digit_register),
    .row_bits_i       (row_ch.row_bits),
    .shift_step_i     (row_ch.shift_step),
    .last_of_run_i    (row_ch.last_of_run),
    .mismatches_o     (mismatches),
    .pending_o        (pending),
    .rows_checked_o   (rows_checked)
  );

  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Run exceeded %0d cycles with %0d row writes pending", CYCLE_LIMIT, pending);
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Receiver: mix random stalls with ready stretches; hold ready in the tail
  initial begin
    row_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (calm || $urandom_range(0, 2) != 0) begin
        row_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk_i);
      end else begin
        row_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end
    end
  end

  function automatic logic [7:0] random_code();
    if ($urandom_range(0, 6) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(FONT_FIRST, LAST_CODE));
  endfunction

  // Present one character and hold it until the beat is taken; valid stays high afterwards
  task automatic send_char(input logic [7:0] code, input logic start);
    if (!calm && $urandom_range(0, 3) == 0) begin
      char_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    char_ch.valid          <= 1'b1;
    char_ch.char_code      <= code;
    char_ch.starts_message <= start;
    do @(posedge clk_i); while (!char_ch.ready);
    if (start) loads_sent++;
    else scrolls_sent++;
  endtask

  initial begin : stimulus
    int unsigned sent;
    int unsigned msg_len;
    char_ch.valid          = 1'b0;
    char_ch.char_code      = '0;
    char_ch.starts_message = 1'b0;
    rst_ni                 = 1'b0;
    calm                   = 1'b0;
    scrolls_sent           = 0;
    loads_sent             = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Scroll straight out of reset, before any message has started
    send_char(8'd0, 1'b0);
    send_char(8'd77, 1'b0);
    // Blank loads and scrolls from codes outside the font, mixed with codes at the font's edges
    send_char(8'd255, 1'b1);
    send_char(8'd255, 1'b0);
    send_char(FONT_FIRST, 1'b1);
    send_char(8'd90, 1'b0);
    send_char(8'd47, 1'b0);
    send_char(8'(LAST_CODE + 1), 1'b1);
    send_char(8'(FONT_FIRST - 1), 1'b0);
    send_char(LAST_CODE, 1'b0);
    send_char(8'(LAST_CODE - 1), 1'b0);
    // Back-to-back message starts, then the same glyph again
    send_char(8'd77, 1'b1);
    send_char(8'd81, 1'b1);
    send_char(8'd81, 1'b0);
    send_char(8'd64, 1'b0);
    send_char(8'd52, 1'b0);
    send_char(8'h80, 1'b0);
    send_char(8'h01, 1'b0);
    send_char(8'hAA, 1'b0);
    send_char(8'h55, 1'b1);
    send_char(8'd88, 1'b0);
    send_char(8'd48, 1'b0);

    // Messages with random content; some lack their start and run on from the last one
    sent = 0;
    while (sent < RANDOM_CHARS) begin
      calm = (sent + CALM_TAIL >= RANDOM_CHARS);
      if ($urandom_range(0, 9) != 0) begin
        send_char(random_code(), 1'b1);
        sent++;
      end
      msg_len = $urandom_range(1, 8);
      repeat (msg_len) begin
        send_char(random_code(), 1'b0);
        sent++;
      end
    end
    char_ch.valid <= 1'b0;

    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Scrolled %0d characters and loaded %0d message starts, blank and font codes mixed.",
             scrolls_sent, loads_sent);
    $display("Compared %0d row writes under random stalls; %0d field mismatches.",
             rows_checked, mismatches);
    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
